// ===== sv/gst_pkg.sv =====
`default_nettype none
package gst_pkg;

  localparam int PHASE_BITS_DEF = 10;
  localparam int TIME_BITS_DEF  = 32;

  // Shortest gust window in Q16.16 seconds, about one millisecond.
  localparam logic [31:0] MIN_DURATION = 32'd66;
  localparam logic [31:0] DURATION_RST = 32'd65536;

  // Quarter-wave cosine polynomial coefficients, Q16.
  localparam logic [16:0] COS_K0 = 17'd60;
  localparam logic [16:0] COS_K1 = 17'd1367;
  localparam logic [16:0] COS_K2 = 17'd16625;
  localparam logic [16:0] COS_K3 = 17'd80852;
  localparam logic [16:0] COS_ONE = 17'd65536;
  localparam logic [14:0] QUARTER_TURN = 15'd16384;

  localparam int CFG_IDX_BITS = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STEADY_NORTH  = 4'd0,
    REG_STEADY_EAST   = 4'd1,
    REG_STEADY_DOWN   = 4'd2,
    REG_GUST_NORTH    = 4'd3,
    REG_GUST_EAST     = 4'd4,
    REG_GUST_DOWN     = 4'd5,
    REG_GUST_START    = 4'd6,
    REG_GUST_DURATION = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic in_win;
  } ctl_t;

  typedef logic [2:0][15:0] vec3_t;

endpackage
`default_nettype wire

// ===== sv/one_minus_cosine_gust_wind_unit.sv =====
// Channel  Ports                                        Handshake
// input    start, busy, in_sample_time                  start && !busy
// result   out_valid, out_wind_*, out_in_gust           out_valid, one cycle
// config   cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid && cfg_ready
//
// One word per cycle; a word passes PHASE_BITS + 10 register stages on its way to the
// result ports. The stages are the divider, one quotient bit per stage after its entry
// register, the seven-stage cosine chain and the mixer registers. busy is always
// low and cfg_ready always high. Reset is synchronous and clears the pipeline valid
// bits and the configuration registers, but sets the duration to DURATION_RST.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module one_minus_cosine_gust_wind_unit #(
  parameter int PHASE_BITS = gst_pkg::PHASE_BITS_DEF,
  parameter int TIME_BITS  = gst_pkg::TIME_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [31:0]                    in_sample_time,
  output logic                                out_valid,
  output logic signed [15:0]                  out_wind_north,
  output logic signed [15:0]                  out_wind_east,
  output logic signed [15:0]                  out_wind_down,
  output logic                                out_in_gust,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gst_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import gst_pkg::*;

  vec3_t       steady_r, gust_r;
  logic [31:0] start_r, dur_r;
  logic        acc;

  ctl_t                  div_ctl, cos_ctl;
  logic [PHASE_BITS-1:0] div_q;
  logic [16:0]           cos_f;
  vec3_t                 wind;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steady_r <= '0;
      gust_r   <= '0;
      start_r  <= '0;
      dur_r    <= DURATION_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEADY_NORTH:  steady_r[0] <= cfg_data[15:0];
        REG_STEADY_EAST:   steady_r[1] <= cfg_data[15:0];
        REG_STEADY_DOWN:   steady_r[2] <= cfg_data[15:0];
        REG_GUST_NORTH:    gust_r[0]   <= cfg_data[15:0];
        REG_GUST_EAST:     gust_r[1]   <= cfg_data[15:0];
        REG_GUST_DOWN:     gust_r[2]   <= cfg_data[15:0];
        REG_GUST_START:    start_r     <= cfg_data;
        REG_GUST_DURATION: dur_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  gst_div #(.TIME_BITS(TIME_BITS), .PHASE_BITS(PHASE_BITS)) u_div (
    .clk, .rst_n, .acc_i(acc), .time_i(in_sample_time), .start_i(start_r),
    .dur_i(dur_r), .ctl_o(div_ctl), .q_o(div_q)
  );

  gst_cos #(.PHASE_BITS(PHASE_BITS)) u_cos (
    .clk, .rst_n, .ctl_i(div_ctl), .q_i(div_q), .ctl_o(cos_ctl), .f_o(cos_f)
  );

  gst_mix u_mix (
    .clk, .rst_n, .ctl_i(cos_ctl), .f_i(cos_f), .steady_i(steady_r), .gust_i(gust_r),
    .valid_o(out_valid), .in_gust_o(out_in_gust), .wind_o(wind)
  );

  assign out_wind_north = wind[0];
  assign out_wind_east  = wind[1];
  assign out_wind_down  = wind[2];

endmodule
`default_nettype wire

// ===== sv/gst_div.sv =====
`default_nettype none
module gst_div #(
  parameter int TIME_BITS  = gst_pkg::TIME_BITS_DEF,
  parameter int PHASE_BITS = gst_pkg::PHASE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  acc_i,
  input  wire logic [31:0]           time_i,
  input  wire logic [31:0]           start_i,
  input  wire logic [31:0]           dur_i,
  output gst_pkg::ctl_t              ctl_o,
  output logic [PHASE_BITS-1:0]      q_o
);
  import gst_pkg::*;

  logic [TIME_BITS-1:0] t_tb, s_tb, dur_raw, dur_eff, d;
  logic                 in_win;

  ctl_t                  ctl_r [PHASE_BITS+1];
  logic [TIME_BITS-1:0]  rem_r [PHASE_BITS+1];
  logic [PHASE_BITS-1:0] q_r   [PHASE_BITS+1];

  assign t_tb    = TIME_BITS'(time_i);
  assign s_tb    = TIME_BITS'(start_i);
  assign dur_raw = TIME_BITS'(dur_i);
  assign dur_eff = (dur_raw < TIME_BITS'(MIN_DURATION)) ? TIME_BITS'(MIN_DURATION) : dur_raw;
  assign d       = t_tb - s_tb;
  assign in_win  = acc_i && (t_tb > s_tb) && (d < dur_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else begin
      ctl_r[0] <= '{valid: acc_i, in_win: in_win};
    end
    rem_r[0] <= d;
    q_r[0]   <= '0;
  end

  // One quotient bit per stage; for words inside the window the remainder stays below the duration.
  for (genvar i = 0; i < PHASE_BITS; i++) begin : g_step
    logic [TIME_BITS:0]   rem2;
    logic                 ge;
    logic [TIME_BITS-1:0] rem_nxt;

    assign rem2    = {rem_r[i], 1'b0};
    assign ge      = rem2 >= {1'b0, dur_eff};
    assign rem_nxt = ge ? TIME_BITS'(rem2 - {1'b0, dur_eff}) : TIME_BITS'(rem2);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i+1] <= '0;
      end else begin
        ctl_r[i+1] <= ctl_r[i];
      end
      rem_r[i+1] <= rem_nxt;
      q_r[i+1]   <= {q_r[i][PHASE_BITS-2:0], ge};
    end
  end

  assign ctl_o = ctl_r[PHASE_BITS];
  assign q_o   = q_r[PHASE_BITS];

  a_entry_in_win: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[0].in_win |-> ctl_r[0].valid) else $error("window flag without word");
  a_out_in_win: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_o.in_win |-> ctl_o.valid) else $error("window flag lost its word");
  a_out_chain: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_o.valid |-> $past(ctl_r[PHASE_BITS-1].valid)) else $error("divider word appeared");

endmodule
`default_nettype wire

// ===== sv/gst_cos.sv =====
`default_nettype none
module gst_cos #(
  parameter int PHASE_BITS = gst_pkg::PHASE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  gst_pkg::ctl_t              ctl_i,
  input  wire logic [PHASE_BITS-1:0] q_i,
  output gst_pkg::ctl_t              ctl_o,
  output logic [16:0]                f_o
);
  import gst_pkg::*;

  logic [15:0] p;
  logic [14:0] x_nxt;
  logic [16:0] u;
  logic [33:0] uu, m1, m2, m3, m4;
  logic [16:0] h1_nxt, h2_nxt, h3_nxt, q_nxt;
  logic signed [19:0] qv;
  logic [17:0] cp;
  logic signed [17:0] c, fv;
  logic neg;

  ctl_t        ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r, ctl7_r;
  logic [1:0]  quad1_r, quad2_r, quad3_r, quad4_r, quad5_r, quad6_r;
  logic [14:0] x_r;
  logic [16:0] w2_r, w3_r, w4_r, w5_r;
  logic [16:0] h1_r, h2_r, h3_r, q_r;
  logic [16:0] f_r;

  assign p = 16'(q_i) << (16 - PHASE_BITS);
  assign x_nxt = p[14] ? 15'(QUARTER_TURN - {1'b0, p[13:0]}) : {1'b0, p[13:0]};

  assign u  = {x_r, 2'b00};
  assign uu = 34'(u) * 34'(u);

  assign m1 = 34'(w2_r) * 34'(COS_K0);
  assign h1_nxt = 17'(18'(COS_K1) - m1[33:16]);
  assign m2 = 34'(w3_r) * 34'(h1_r);
  assign h2_nxt = 17'(18'(COS_K2) - m2[33:16]);
  assign m3 = 34'(w4_r) * 34'(h2_r);
  assign h3_nxt = 17'(18'(COS_K3) - m3[33:16]);
  assign m4 = 34'(w5_r) * 34'(h3_r);
  assign qv = $signed({3'b000, COS_ONE}) - $signed({2'b00, m4[33:16]});
  assign q_nxt = (qv < 0) ? 17'd0 : ((qv > $signed({3'b000, COS_ONE})) ? COS_ONE : qv[16:0]);

  // Round to Q1.15, apply the quadrant sign, then form one minus cosine.
  assign cp  = (18'(q_r) + 18'd1) >> 1;
  assign neg = (quad6_r == 2'd1) || (quad6_r == 2'd2);
  assign c   = neg ? -$signed(cp) : ((cp > 18'd32767) ? 18'sd32767 : $signed(cp));
  assign fv  = 18'sd32768 - c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0; ctl2_r <= '0; ctl3_r <= '0; ctl4_r <= '0;
      ctl5_r <= '0; ctl6_r <= '0; ctl7_r <= '0;
    end else begin
      ctl1_r <= ctl_i; ctl2_r <= ctl1_r; ctl3_r <= ctl2_r; ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r; ctl6_r <= ctl5_r; ctl7_r <= ctl6_r;
    end
    quad1_r <= p[15:14];
    x_r     <= x_nxt;
    quad2_r <= quad1_r;
    w2_r    <= uu[32:16];
    quad3_r <= quad2_r;
    w3_r    <= w2_r;
    quad4_r <= quad3_r;
    w4_r    <= w3_r;
    quad5_r <= quad4_r;
    w5_r    <= w4_r;
    quad6_r <= quad5_r;
    f_r     <= ctl6_r.in_win ? 17'(fv) : 17'd0;
  end

  // Stage pipeline of the Horner chain: h1 is registered at stage three from w2.
  always_ff @(posedge clk) begin
    h1_r <= h1_nxt;
    h2_r <= h2_nxt;
    h3_r <= h3_nxt;
    q_r  <= q_nxt;
  end

  assign ctl_o = ctl7_r;
  assign f_o   = f_r;

  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl7_r.valid && !ctl7_r.in_win) |-> (f_r == 17'd0)) else $error("factor outside window");
  a_nonzero_in_win: assert property (@(posedge clk) disable iff (!rst_n)
    ctl7_r.in_win |-> (f_r != 17'd0 && f_r <= COS_ONE)) else $error("factor out of range");
  a_chain: assert property (@(posedge clk) disable iff (!rst_n)
    ctl7_r.valid |-> $past(ctl6_r.valid)) else $error("cosine word appeared");

endmodule
`default_nettype wire

// ===== sv/gst_mix.sv =====
`default_nettype none
module gst_mix (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  gst_pkg::ctl_t      ctl_i,
  input  wire logic [16:0]   f_i,
  input  gst_pkg::vec3_t     steady_i,
  input  gst_pkg::vec3_t     gust_i,
  output logic               valid_o,
  output logic               in_gust_o,
  output gst_pkg::vec3_t     wind_o
);
  import gst_pkg::*;

  logic signed [33:0] prod [3];
  logic signed [33:0] biased [3];
  logic signed [18:0] sum [3];
  logic [2:0][17:0]   sc_nxt;
  vec3_t              wind_nxt;

  ctl_t               ctl1_r;
  logic [2:0][17:0]   sc_r;
  logic               valid_r, in_gust_r;
  vec3_t              wind_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a]   = 34'($signed(gust_i[a])) * 34'($signed({1'b0, f_i}));
      biased[a] = prod[a] + 34'sd32768;
      sc_nxt[a] = 18'(biased[a] >>> 16);
      sum[a]    = 19'($signed(sc_r[a])) + 19'($signed(steady_i[a]));
      if (sum[a] > 19'sd32767) begin
        wind_nxt[a] = 16'h7FFF;
      end else if (sum[a] < -19'sd32768) begin
        wind_nxt[a] = 16'h8000;
      end else begin
        wind_nxt[a] = sum[a][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      ctl1_r  <= ctl_i;
      valid_r <= ctl1_r.valid;
    end
    sc_r      <= sc_nxt;
    in_gust_r <= ctl1_r.in_win;
    wind_r    <= wind_nxt;
  end

  assign valid_o   = valid_r;
  assign in_gust_o = in_gust_r;
  assign wind_o    = wind_r;

endmodule
`default_nettype wire

// ===== bench/gust_wind_checker.sv =====
`default_nettype none
module gust_wind_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [31:0] in_sample_time,
  input  wire logic        out_valid,
  input  wire logic [15:0] out_wind_north,
  input  wire logic [15:0] out_wind_east,
  input  wire logic [15:0] out_wind_down,
  input  wire logic        out_in_gust,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [gst_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               mismatches,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gst_pkg::*;

  localparam int PHASE_DROP = 16 - PHASE_BITS_DEF;

  typedef struct {
    logic signed [15:0] north;
    logic signed [15:0] east;
    logic signed [15:0] down;
    logic               in_win;
  } wind_t;

  logic signed [15:0] steady_n, steady_e, steady_d, gust_n, gust_e, gust_d;
  logic [31:0]        win_start, win_len;
  wind_t              wind_q[$];

  function automatic longint quarter_wave(longint x);
    longint u, w, h;
    u = x * 4;
    w = (u * u) / 65536;
    h = COS_K0;
    h = longint'(COS_K1) - (w * h) / 65536;
    h = longint'(COS_K2) - (w * h) / 65536;
    h = longint'(COS_K3) - (w * h) / 65536;
    h = longint'(COS_ONE) - (w * h) / 65536;
    if (h < 0) h = 0;
    if (h > 65536) h = 65536;
    return h;
  endfunction

  function automatic longint cosine_q15(logic [15:0] p);
    logic [1:0] quad;
    longint r, q, c;
    quad = p[15:14];
    r = p[13:0];
    q = (quad == 0 || quad == 2) ? quarter_wave(r) : quarter_wave(16384 - r);
    c = (q + 1) / 2;
    if (quad == 1 || quad == 2) c = -c;
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    return c;
  endfunction

  function automatic logic signed [15:0] gusted(logic signed [15:0] base,
                                                logic signed [15:0] amp, longint f);
    longint sum;
    sum = longint'(base) + ((longint'(amp) * f + 32768) >>> 16);
    if (sum > 32767) sum = 32767;
    if (sum < -32768) sum = -32768;
    return sum[15:0];
  endfunction

  function automatic wind_t wind_at(logic [31:0] t);
    wind_t  w;
    longint unsigned d, len, tau;
    logic [15:0] p;
    longint f;
    f = 0;
    w.in_win = 1'b0;
    len = (win_len < MIN_DURATION) ? MIN_DURATION : win_len;
    if (t > win_start) begin
      d = t - win_start;
      if (d < len) begin
        tau = (d << 16) / len;
        p = tau[15:0];
        p = (p >> PHASE_DROP) << PHASE_DROP;
        w.in_win = 1'b1;
        f = 32768 - cosine_q15(p);
      end
    end
    w.north = gusted(steady_n, gust_n, f);
    w.east  = gusted(steady_e, gust_e, f);
    w.down  = gusted(steady_d, gust_d, f);
    return w;
  endfunction

  assign pending = wind_q.size();

  always @(posedge clk) begin
    wind_t exp_w;
    if (!rst_n) begin
      steady_n <= '0; steady_e <= '0; steady_d <= '0;
      gust_n <= '0; gust_e <= '0; gust_d <= '0;
      win_start <= '0;
      win_len <= DURATION_RST;
      wind_q.delete();
      mismatches <= 0;
    end else begin
      if (out_valid) begin
        if (wind_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result word at %0t", $realtime);
        end else begin
          exp_w = wind_q.pop_front();
          if (exp_w.north !== out_wind_north || exp_w.east !== out_wind_east ||
              exp_w.down !== out_wind_down || exp_w.in_win !== out_in_gust) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp n=%0d e=%0d d=%0d g=%0b got n=%0d e=%0d d=%0d g=%0b",
                       exp_w.north, exp_w.east, exp_w.down, exp_w.in_win,
                       $signed(out_wind_north), $signed(out_wind_east),
                       $signed(out_wind_down), out_in_gust);
          end
        end
      end
      if (start && !busy) wind_q.push_back(wind_at(in_sample_time));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEADY_NORTH:  steady_n <= cfg_data[15:0];
          REG_STEADY_EAST:   steady_e <= cfg_data[15:0];
          REG_STEADY_DOWN:   steady_d <= cfg_data[15:0];
          REG_GUST_NORTH:    gust_n <= cfg_data[15:0];
          REG_GUST_EAST:     gust_e <= cfg_data[15:0];
          REG_GUST_DOWN:     gust_d <= cfg_data[15:0];
          REG_GUST_START:    win_start <= cfg_data;
          REG_GUST_DURATION: win_len <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== bench/tb_one_minus_cosine_gust_wind_unit.sv =====
`default_nettype none
module tb_one_minus_cosine_gust_wind_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gst_pkg::*;

  localparam int LATENCY   = PHASE_BITS_DEF + 10;
  localparam int STALL_CAP = 2000;
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_HI = 4'd15;

  logic clk = 1'b0, rst_n = 1'b0;
  logic start = 1'b0, cfg_valid = 1'b0;
  logic [31:0] in_sample_time = '0, cfg_data = '0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic busy, out_valid, out_in_gust, cfg_ready;
  logic signed [15:0] out_wind_north, out_wind_east, out_wind_down;
  int mismatches, pending, idle_cycles = 0;
  logic [31:0] win_start = '0, win_len = DURATION_RST;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  one_minus_cosine_gust_wind_unit i_dut (.*);
  gust_wind_checker i_chk (.*);

  // Ends the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(logic [31:0] t);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_sample_time <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_GUST_START) win_start = data;
    if (idx == REG_GUST_DURATION) win_len = data;
  endtask

  // Lets the pipeline empty so the registers can be changed safely.
  task automatic drain;
    start <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_wind(logic [15:0] sn, se, sd, gn, ge, gd, logic [31:0] s, len);
    write_reg(REG_STEADY_NORTH, {16'h0, sn});
    write_reg(REG_STEADY_EAST, {16'h0, se});
    write_reg(REG_STEADY_DOWN, {16'h0, sd});
    write_reg(REG_GUST_NORTH, {16'h0, gn});
    write_reg(REG_GUST_EAST, {16'h0, ge});
    write_reg(REG_GUST_DOWN, {16'h0, gd});
    write_reg(REG_GUST_START, s);
    write_reg(REG_GUST_DURATION, len);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic window_edges;
    logic [31:0] len;
    len = (win_len < MIN_DURATION) ? MIN_DURATION : win_len;
    send_word(32'h0);
    send_word(32'hFFFF_FFFF);
    send_word(win_start);
    send_word(win_start + 1);
    send_word(win_start + len);
    send_word(win_start + len - 1);
    send_word(win_start + len / 2);
    send_word(win_start + len / 4);
    send_word(win_start + (len / 4) * 3);
  endtask

  task automatic random_words(int n);
    logic [31:0] len;
    len = (win_len < MIN_DURATION) ? MIN_DURATION : win_len;
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) send_word(win_start + $urandom_range(0, len));
      else send_word($urandom);
    end
  endtask

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 65);
      1: return $urandom;
      2: return $urandom_range(66, 4096);
      default: return $urandom_range(66, 1 << 20);
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values first: one second window from zero, no wind.
    window_edges();
    drain();
    set_wind(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
             32'd1000, 32'd0);
    window_edges();
    drain();
    set_wind(16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF,
             32'hFFFF_0000, 32'hFFFF_FFFF);
    window_edges();
    drain();
    // Writes to unused indexes must leave every register alone.
    write_reg(IDX_SPARE_LO, $urandom);
    write_reg(IDX_SPARE_HI, $urandom);
    cfg_valid <= 1'b0;
    window_edges();
    drain();

    repeat (10) begin
      set_wind(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom), $urandom, pick_len());
      random_words(118);
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
